@@ sv/gst_pkg.sv @@
// gst_pkg: shared types and constants for the generational slot table.
// No dependencies; used by every module of the block.
package gst_pkg;

  localparam int MAX_SLOTS   = 256;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int DEPTH_W     = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W       = 8;
  localparam int GEN_W       = 32;
  localparam int VAL_W       = 64;
  localparam int WARN_W      = 9;
  localparam int STATUS_W    = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNSET     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SHUTDOWN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STALE     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd6;

  localparam logic REG_WARN_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    REQ_ALLOC    = 2'd0,
    REQ_FREE     = 2'd1,
    REQ_RESOLVE  = 2'd2,
    REQ_SHUTDOWN = 2'd3
  } gst_req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SLOT,
    BK_EXEC,
    BK_DIV
  } gst_state_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic             handle_is_set;
    logic [IDX_W-1:0] handle_index;
    logic [GEN_W-1:0] handle_generation;
    logic [VAL_W-1:0] payload_value;
  } gst_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot_index;
    logic [GEN_W-1:0]    slot_generation;
    logic [VAL_W-1:0]    resolved_value;
    logic                soft_warn;
    logic [WARN_W-1:0]   warn_level_reached;
  } gst_out_t;

  // Classified request as it sits in the queue.
  typedef struct packed {
    gst_req_t         req;
    logic             null_payload;
    logic             unset_handle;
    logic [IDX_W-1:0] handle_index;
    logic [GEN_W-1:0] handle_generation;
    logic [VAL_W-1:0] payload_value;
  } gst_work_t;

endpackage

@@ sv/gst_front.sv @@
// gst_front: accepts requests and classifies them for the back end.
// Depends on gst_pkg.
module gst_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  gst_pkg::gst_in_t   in_data,
  input  logic               q_full,
  output logic               q_push,
  output gst_pkg::gst_work_t q_wdata
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.req               = gst_pkg::gst_req_t'(in_data.req_type);
    q_wdata.null_payload      = (in_data.payload_value == '0);
    q_wdata.unset_handle      = !in_data.handle_is_set;
    q_wdata.handle_index      = in_data.handle_index;
    q_wdata.handle_generation = in_data.handle_generation;
    q_wdata.payload_value     = in_data.payload_value;
  end

endmodule

@@ sv/gst_fifo.sv @@
// gst_fifo: short request queue between front and back end.
// Depends on gst_pkg.
module gst_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gst_pkg::gst_work_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               rvalid,
  output gst_pkg::gst_work_t rdata
);

  gst_pkg::gst_work_t                 mem_r [gst_pkg::QUEUE_DEPTH];
  logic [gst_pkg::QPTR_W-1:0]         wr_ptr_r, rd_ptr_r;
  logic [gst_pkg::QPTR_W:0]           count_r;
  logic                               do_push, do_pop;

  assign full    = (count_r == (gst_pkg::QPTR_W+1)'(gst_pkg::QUEUE_DEPTH));
  assign rvalid  = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

@@ sv/gst_div.sv @@
// gst_div: restoring divider, one quotient bit per cycle.
// Depends on gst_pkg.
module gst_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gst_pkg::WARN_W-1:0] dividend,
  input  logic [gst_pkg::WARN_W-1:0] divisor,
  output logic                       done,
  output logic [gst_pkg::WARN_W-1:0] quotient,
  output logic [gst_pkg::WARN_W-1:0] remainder
);

  localparam int CNT_W = $clog2(gst_pkg::WARN_W);

  logic [gst_pkg::WARN_W:0]   rem_r;
  logic [gst_pkg::WARN_W-1:0] quo_r, dsr_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r, done_r;
  logic [gst_pkg::WARN_W:0]   shifted, diff;
  logic                       fits;

  assign shifted   = {rem_r[gst_pkg::WARN_W-1:0], quo_r[gst_pkg::WARN_W-1]};
  assign diff      = shifted - {1'b0, dsr_r};
  assign fits      = (shifted >= {1'b0, dsr_r});
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[gst_pkg::WARN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(gst_pkg::WARN_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff : shifted;
      quo_r <= {quo_r[gst_pkg::WARN_W-2:0], fits};
    end
  end

endmodule

@@ sv/gst_back.sv @@
// gst_back: executes queued requests against the slot, generation and free-stack memories.
// Depends on gst_pkg and gst_div.
module gst_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  gst_pkg::gst_work_t         q_data,
  output logic                       q_pop,
  input  logic [gst_pkg::WARN_W-1:0] warn_threshold,
  input  logic                       out_free,
  output logic                       res_load,
  output gst_pkg::gst_out_t          res_data
);

  localparam int MARK_W = 2 * gst_pkg::WARN_W + 1;

  gst_pkg::gst_state_t state_r, state_nxt;

  // storage
  logic [gst_pkg::VAL_W-1:0]  pay_mem   [gst_pkg::MAX_SLOTS];
  logic [gst_pkg::GEN_W-1:0]  gen_mem   [gst_pkg::MAX_SLOTS];
  logic [gst_pkg::SLOT_W-1:0] stack_mem [gst_pkg::MAX_SLOTS];
  logic [gst_pkg::MAX_SLOTS-1:0] gen_vld_r;

  logic [gst_pkg::DEPTH_W-1:0] depth_r, grown_r, grown_inc;
  logic [gst_pkg::WARN_W-1:0]  highest_r;
  logic                        shut_r;

  // per-request working registers
  gst_pkg::gst_work_t          work_r;
  logic [gst_pkg::SLOT_W-1:0]  stack_q, slot_r, slot_sel;
  logic [gst_pkg::GEN_W-1:0]   gen_q, gen_cur, gen_inc;
  logic                        gvld_q;
  logic [gst_pkg::VAL_W-1:0]   pay_q;
  logic [MARK_W-1:0]           mark_r, mark_nxt;
  gst_pkg::gst_out_t           res_r, res_c, res_div;

  logic commit, div_start, need_div;
  logic do_pop, do_grow, do_set, do_free, do_push, do_shut;
  logic warn_hit, warn_exact;
  logic [gst_pkg::STATUS_W-1:0] status_c;
  logic [gst_pkg::VAL_W-1:0]    value_c;

  logic                       div_done;
  logic [gst_pkg::WARN_W-1:0] div_quo, div_rem;

  // slot and generation arithmetic
  always_comb begin
    if (work_r.req == gst_pkg::REQ_ALLOC) begin
      slot_sel = (depth_r != '0) ? stack_q : gst_pkg::SLOT_W'(grown_r);
    end else begin
      slot_sel = gst_pkg::SLOT_W'(work_r.handle_index);
    end
    gen_cur   = gvld_q ? gen_q : '0;
    gen_inc   = (&gen_cur) ? gst_pkg::GEN_W'(1) : gen_cur + 1'b1;
    grown_inc = grown_r + 1'b1;
    mark_nxt  = (MARK_W'(highest_r) + MARK_W'(1)) * MARK_W'(warn_threshold);
    warn_hit  = (warn_threshold != '0) && (MARK_W'(grown_inc) >= mark_r);
    warn_exact = (warn_threshold != '0) && (MARK_W'(grown_inc) == mark_r);
  end

  // request checks
  always_comb begin
    status_c = gst_pkg::ST_OK;
    value_c  = '0;
    do_pop   = 1'b0;
    do_grow  = 1'b0;
    do_set   = 1'b0;
    do_free  = 1'b0;
    do_shut  = 1'b0;
    case (work_r.req)
      gst_pkg::REQ_ALLOC: begin
        if (work_r.null_payload)  status_c = gst_pkg::ST_NULL;
        else if (shut_r)          status_c = gst_pkg::ST_SHUTDOWN;
        else if (depth_r != '0) begin
          do_pop = 1'b1;
          do_set = 1'b1;
        end else if (grown_r == gst_pkg::DEPTH_W'(gst_pkg::MAX_SLOTS)) begin
          status_c = gst_pkg::ST_FULL;
        end else begin
          do_grow = 1'b1;
          do_set  = 1'b1;
        end
      end
      gst_pkg::REQ_FREE, gst_pkg::REQ_RESOLVE: begin
        if (work_r.unset_handle) status_c = gst_pkg::ST_UNSET;
        else if (shut_r)         status_c = gst_pkg::ST_SHUTDOWN;
        else if (gst_pkg::DEPTH_W'(work_r.handle_index) >= grown_r) begin
          status_c = gst_pkg::ST_RANGE;
        end else if (gen_cur != work_r.handle_generation) begin
          status_c = gst_pkg::ST_STALE;
        end else if (work_r.req == gst_pkg::REQ_FREE) begin
          do_free = 1'b1;
        end else begin
          value_c = pay_q;
        end
      end
      gst_pkg::REQ_SHUTDOWN: do_shut = 1'b1;
      default: status_c = gst_pkg::ST_OK;
    endcase
    do_push  = do_free && (depth_r < gst_pkg::DEPTH_W'(gst_pkg::MAX_SLOTS));
    need_div = do_grow && warn_hit && !warn_exact;
  end

  always_comb begin
    res_c.status             = status_c;
    res_c.slot_index         = do_set ? gst_pkg::IDX_W'(slot_r) : '0;
    res_c.slot_generation    = do_set ? gen_inc : '0;
    res_c.resolved_value     = value_c;
    res_c.soft_warn          = do_grow && warn_exact;
    res_c.warn_level_reached = (do_grow && warn_exact) ? gst_pkg::WARN_W'(mark_r) : '0;

    res_div                    = res_r;
    res_div.soft_warn          = 1'b1;
    res_div.warn_level_reached = gst_pkg::WARN_W'(grown_r) - div_rem;

    res_data = (state_r == gst_pkg::BK_DIV) ? res_div : res_c;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    commit    = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    case (state_r)
      gst_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = gst_pkg::BK_SLOT;
        end
      end
      gst_pkg::BK_SLOT: state_nxt = gst_pkg::BK_EXEC;
      gst_pkg::BK_EXEC: begin
        if (out_free) begin
          commit = 1'b1;
          if (need_div) begin
            div_start = 1'b1;
            state_nxt = gst_pkg::BK_DIV;
          end else begin
            res_load  = 1'b1;
            state_nxt = gst_pkg::BK_IDLE;
          end
        end
      end
      gst_pkg::BK_DIV: begin
        // output register was drained when EXEC committed
        if (div_done) begin
          res_load  = 1'b1;
          state_nxt = gst_pkg::BK_IDLE;
        end
      end
      default: state_nxt = gst_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= gst_pkg::BK_IDLE;
    else        state_r <= state_nxt;
  end

  // table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= '0;
      grown_r   <= '0;
      highest_r <= '0;
      shut_r    <= 1'b0;
      gen_vld_r <= '0;
    end else begin
      if (commit) begin
        if (do_pop)  depth_r <= depth_r - 1'b1;
        if (do_push) depth_r <= depth_r + 1'b1;
        if (do_grow) grown_r <= grown_inc;
        if (do_shut) shut_r  <= 1'b1;
        if (do_grow && warn_exact) highest_r <= highest_r + 1'b1;
        if (do_set || do_free) gen_vld_r[slot_r] <= 1'b1;
      end
      if (state_r == gst_pkg::BK_DIV && div_done) highest_r <= div_quo;
    end
  end

  // memories and working registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_r  <= q_data;
      stack_q <= stack_mem[gst_pkg::SLOT_W'(depth_r - 1'b1)];
    end
    if (state_r == gst_pkg::BK_SLOT) begin
      slot_r <= slot_sel;
      gen_q  <= gen_mem[slot_sel];
      gvld_q <= gen_vld_r[slot_sel];
      pay_q  <= pay_mem[slot_sel];
      mark_r <= mark_nxt;
    end
    if (commit) begin
      res_r <= res_c;
      if (do_set || do_free) begin
        gen_mem[slot_r] <= gen_inc;
        pay_mem[slot_r] <= do_set ? work_r.payload_value : '0;
      end
      if (do_push) stack_mem[gst_pkg::SLOT_W'(depth_r)] <= slot_r;
    end
  end

  gst_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (gst_pkg::WARN_W'(grown_inc)),
    .divisor   (warn_threshold),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

endmodule

@@ sv/generational_slot_table_top.sv @@
// A request shows on out_valid after the queue pop, the slot read and the execute step;
// a grow that passes the next warning multiple without landing on it also waits for the
// divider, and a stalled output register holds off the execute step.
// The back end takes the next request from the queue only once the current one is done.
// Reset: synchronous, active low; clears counters, shutdown, queue and generation valid bits.
module generational_slot_table_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  gst_pkg::gst_in_t           in_data,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output gst_pkg::gst_out_t          out_data,
  // configuration port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [gst_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [gst_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [gst_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  // Configuration: one register, warn_threshold, at byte address 0.
  // Register index is the word address bit; anything past it is ignored.
  logic [gst_pkg::WARN_W-1:0] warn_thr_r;
  logic                       cfg_wr;
  logic                       cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_hit    = (cfg_paddr[2] == gst_pkg::REG_WARN_THRESHOLD);
  assign cfg_prdata = cfg_hit ? gst_pkg::DATA_W'(warn_thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_thr_r <= '0;
    end else if (cfg_wr && cfg_hit) begin
      warn_thr_r <= cfg_pwdata[gst_pkg::WARN_W-1:0];
    end
  end

  // Front end: classify and push into the request queue.
  logic               q_full, q_push, q_valid, q_pop;
  gst_pkg::gst_work_t q_wdata, q_rdata;

  gst_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  gst_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // Back end: reads slot state, checks the handle, updates memories.
  // It only commits when the output register can take the result.
  logic              out_free, res_load;
  gst_pkg::gst_out_t res_data;

  gst_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .warn_threshold (warn_thr_r),
    .out_free       (out_free),
    .res_load       (res_load),
    .res_data       (res_data)
  );

  // Output register: decouples result delivery from the back end.
  logic              out_valid_r;
  gst_pkg::gst_out_t out_data_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_data_r <= res_data;
  end

endmodule

@@ tb/sv/generational_slot_table_top_test.sv @@
// Self-checking testbench for generational_slot_table_top: handle allocate, free,
// resolve and shutdown requests checked against a cycle-free predictor of the slot state.
// Depends on gst_pkg and the generational_slot_table_top RTL only.
module generational_slot_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte address of the single config register.
  localparam logic [gst_pkg::ADDR_W-1:0] WARN_ADDR =
      gst_pkg::ADDR_W'(4 * int'(gst_pkg::REG_WARN_THRESHOLD));

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  gst_pkg::gst_in_t              in_data;
  logic                          out_valid;
  logic                          out_stall;
  gst_pkg::gst_out_t             out_data;
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [gst_pkg::ADDR_W-1:0]    cfg_paddr;
  logic [gst_pkg::DATA_W-1:0]    cfg_pwdata;
  logic [gst_pkg::DATA_W-1:0]    cfg_prdata;
  logic                          cfg_pready;

  generational_slot_table_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted slot state. Updated once per accepted request, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [gst_pkg::GEN_W-1:0] slot_gen     [gst_pkg::MAX_SLOTS];
  logic [gst_pkg::VAL_W-1:0] slot_payload [gst_pkg::MAX_SLOTS];
  int               free_slots   [gst_pkg::MAX_SLOTS];  // LIFO of recycled slot numbers
  int               free_count;
  int               grown_slots;               // high-water mark of the table
  int               top_multiple;              // highest warning multiple reported
  bit               locked_out;                // shutdown seen
  logic [gst_pkg::WARN_W-1:0] warn_step;       // shadow of warn_threshold

  gst_pkg::gst_out_t pending_results[$];       // results owed by the block, oldest first
  int       mismatches;
  bit       no_idle;                           // set for the tail of the run
  int       gap_pct;                           // chance of a sender gap, per request

  // Generations skip zero on wrap so a zeroed handle can never match.
  function automatic logic [gst_pkg::GEN_W-1:0] bump_gen(logic [gst_pkg::GEN_W-1:0] g);
    return (g == '1) ? gst_pkg::GEN_W'(1) : g + gst_pkg::GEN_W'(1);
  endfunction

  // Shared handle validation for free and resolve; order matters.
  function automatic logic [gst_pkg::STATUS_W-1:0] handle_status(gst_pkg::gst_in_t rq);
    if (!rq.handle_is_set)                                 return gst_pkg::ST_UNSET;
    if (locked_out)                                        return gst_pkg::ST_SHUTDOWN;
    if (int'(rq.handle_index) >= grown_slots)              return gst_pkg::ST_RANGE;
    if (slot_gen[rq.handle_index] != rq.handle_generation) return gst_pkg::ST_STALE;
    return gst_pkg::ST_OK;
  endfunction

  // Apply one request to the predicted state and return the result it owes.
  function automatic gst_pkg::gst_out_t apply_request(gst_pkg::gst_in_t rq);
    gst_pkg::gst_out_t r;
    int       slot;
    int       mult;
    r = '0;
    case (gst_pkg::gst_req_t'(rq.req_type))
      gst_pkg::REQ_ALLOC: begin
        if (rq.payload_value == '0) begin
          r.status = gst_pkg::ST_NULL;
        end else if (locked_out) begin
          r.status = gst_pkg::ST_SHUTDOWN;
        end else if (free_count == 0 && grown_slots >= gst_pkg::MAX_SLOTS) begin
          r.status = gst_pkg::ST_FULL;
        end else begin
          if (free_count > 0) begin
            free_count--;
            slot = free_slots[free_count];
          end else begin
            slot = grown_slots;
            grown_slots++;
            // Warning compares against the current step; a step change can jump
            // several multiples at once.
            if (warn_step != '0) begin
              mult = grown_slots / int'(warn_step);
              if (mult > top_multiple) begin
                top_multiple         = mult;
                r.soft_warn          = 1'b1;
                r.warn_level_reached = gst_pkg::WARN_W'(mult * int'(warn_step));
              end
            end
          end
          slot_payload[slot] = rq.payload_value;
          slot_gen[slot]     = bump_gen(slot_gen[slot]);
          r.status           = gst_pkg::ST_OK;
          r.slot_index       = gst_pkg::IDX_W'(slot);
          r.slot_generation  = slot_gen[slot];
        end
      end
      gst_pkg::REQ_FREE: begin
        r.status = handle_status(rq);
        if (r.status == gst_pkg::ST_OK) begin
          slot_payload[rq.handle_index] = '0;
          slot_gen[rq.handle_index]     = bump_gen(slot_gen[rq.handle_index]);
          // Double frees are legal; the stack just stops growing when full.
          if (free_count < gst_pkg::MAX_SLOTS) begin
            free_slots[free_count] = int'(rq.handle_index);
            free_count++;
          end
        end
      end
      gst_pkg::REQ_RESOLVE: begin
        r.status = handle_status(rq);
        if (r.status == gst_pkg::ST_OK) r.resolved_value = slot_payload[rq.handle_index];
      end
      default: begin
        locked_out = 1'b1;
        r.status   = gst_pkg::ST_OK;
      end
    endcase
    return r;
  endfunction

  function automatic gst_pkg::gst_in_t make_req(gst_pkg::gst_req_t kind, bit is_set, int idx,
                                                logic [gst_pkg::GEN_W-1:0] gen,
                                                logic [gst_pkg::VAL_W-1:0] payload);
    gst_pkg::gst_in_t rq;
    rq.req_type          = kind;
    rq.handle_is_set     = is_set;
    rq.handle_index      = gst_pkg::IDX_W'(idx);
    rq.handle_generation = gen;
    rq.payload_value     = payload;
    return rq;
  endfunction

  // Mostly well-formed traffic: handles point at grown slots and carry the
  // current generation; the rest is stale, unset, out-of-range or garbage.
  function automatic gst_pkg::gst_in_t random_request(bit allow_shutdown);
    gst_pkg::gst_in_t rq;
    int      pick;
    int      idx;
    rq.handle_is_set     = 1'b1;
    rq.handle_index      = gst_pkg::IDX_W'($urandom_range(0, 255));
    rq.handle_generation = $urandom;
    rq.payload_value     = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (allow_shutdown && pick < 5) begin
      rq.req_type = gst_pkg::REQ_SHUTDOWN;
    end else if (pick < 40) begin
      rq.req_type = gst_pkg::REQ_ALLOC;
      if ($urandom_range(0, 29) == 0) rq.payload_value = '0;
    end else begin
      rq.req_type = (pick < 64) ? gst_pkg::REQ_FREE : gst_pkg::REQ_RESOLVE;
      pick = $urandom_range(0, 99);
      if (grown_slots > 0 && pick < 85) begin
        idx = $urandom_range(0, grown_slots - 1);
        rq.handle_index      = gst_pkg::IDX_W'(idx);
        rq.handle_generation = slot_gen[idx];
        if (pick >= 72) rq.handle_generation = slot_gen[idx] - gst_pkg::GEN_W'(1);  // old handle
        if (pick >= 80) rq.handle_is_set = 1'b0;
      end else if (pick < 95) begin
        rq.handle_is_set = 1'($urandom_range(0, 1));
      end
    end
    return rq;
  endfunction

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ns: %s mismatch, expected %h got %h", $realtime, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: inputs move on the falling edge, acceptance is seen at the
  // rising edge. The expectation is computed the moment a request is accepted.
  // ---------------------------------------------------------------------------
  task automatic send_request(gst_pkg::gst_in_t rq);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_request(rq));
  endtask

  // Drain: every request produces a result, so an empty queue plus the
  // worst-case divider latency means the block is quiet.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // APB write of warn_threshold followed by a read back of the same register.
  task automatic write_warn_threshold(logic [gst_pkg::WARN_W-1:0] step);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= WARN_ADDR;
    cfg_pwdata  <= gst_pkg::DATA_W'(step);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    warn_step = step;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("warn_threshold read", 64'(step), 64'(cfg_prdata));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result is matched against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    gst_pkg::gst_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t ns: result with no request pending", $realtime);
      end else begin
        want = pending_results.pop_front();
        check_field("status",             64'(want.status),             64'(out_data.status));
        check_field("slot_index",         64'(want.slot_index),         64'(out_data.slot_index));
        check_field("slot_generation",    64'(want.slot_generation),
                    64'(out_data.slot_generation));
        check_field("resolved_value",     want.resolved_value,          out_data.resolved_value);
        check_field("soft_warn",          64'(want.soft_warn),          64'(out_data.soft_warn));
        check_field("warn_level_reached", 64'(want.warn_level_reached),
                    64'(out_data.warn_level_reached));
      end
    end
  end

  // Receiver back-pressure: random stall bursts, broken up by long calm stretches,
  // and switched off for the tail of the run.
  initial begin : stall_source
    int stall_left;
    int calm_left;
    out_stall  = 1'b0;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !no_idle) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall  <= 1'b0;
        stall_left = 0;
        if (calm_left > 0) begin
          calm_left--;
        end else if (!no_idle && rst_n === 1'b1) begin
          case ($urandom_range(0, 19))
            0, 1, 2: stall_left = $urandom_range(1, 16);
            3:       calm_left  = $urandom_range(60, 300);
            default: ;
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Nothing grown yet: handle checks fall through to range, except unset and null.
  task automatic test_empty_table();
    send_request(make_req(gst_pkg::REQ_RESOLVE, 1, 0, '0, '0));
    send_request(make_req(gst_pkg::REQ_FREE, 1, 255, '1, '1));
    send_request(make_req(gst_pkg::REQ_RESOLVE, 0, 0, '0, 64'h5));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, '0));
  endtask

  // Allocate, resolve, stale and freed handles, double free, LIFO reuse.
  // Step is 1 here so every grow raises a warning.
  task automatic test_handle_lifecycle();
    send_request(make_req(gst_pkg::REQ_ALLOC, 0, 0, '0, '1));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 255, '1, 64'h1));
    send_request(make_req(gst_pkg::REQ_RESOLVE, 1, 0, slot_gen[0], '0));
    send_request(make_req(gst_pkg::REQ_RESOLVE, 1, 1, '0, '0));
    send_request(make_req(gst_pkg::REQ_RESOLVE, 1, 1, '1, '0));
    send_request(make_req(gst_pkg::REQ_RESOLVE, 1, 2, 32'd1, '0));
    send_request(make_req(gst_pkg::REQ_FREE, 1, 0, slot_gen[0], '0));
    send_request(make_req(gst_pkg::REQ_RESOLVE, 1, 0, slot_gen[0] - 32'd1, '0));
    // freed slot resolved with its current generation: ok, value zero
    send_request(make_req(gst_pkg::REQ_RESOLVE, 1, 0, slot_gen[0], '0));
    // second free of the same slot pushes it again
    send_request(make_req(gst_pkg::REQ_FREE, 1, 0, slot_gen[0], '0));
    send_request(make_req(gst_pkg::REQ_FREE, 1, 1, slot_gen[1], '0));
    send_request(make_req(gst_pkg::REQ_FREE, 1, 1, slot_gen[1] + 32'd5, '0));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, 64'h8000_0000_0000_0000));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, 64'h0123_4567_89ab_cdef));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, 64'hfedc_ba98_7654_3210));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, 64'h2));
    send_request(make_req(gst_pkg::REQ_FREE, 0, 0, slot_gen[0], '0));
    send_request(make_req(gst_pkg::REQ_RESOLVE, 0, 1, slot_gen[1], '0));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 3, '1, '0));
    send_request(make_req(gst_pkg::REQ_RESOLVE, 1, 2, slot_gen[2], '0));
  endtask

  // Grow with warnings off, then re-enable with step 2 so one grow
  // leaps several multiples; also touch the step extremes.
  task automatic test_warn_rescale();
    wait_idle();
    write_warn_threshold(gst_pkg::WARN_W'(0));
    repeat (6)
      send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, {$urandom, $urandom} | 64'h1));
    wait_idle();
    write_warn_threshold(gst_pkg::WARN_W'(2));
    repeat (3)
      send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, {$urandom, $urandom} | 64'h1));
    wait_idle();
    write_warn_threshold(gst_pkg::WARN_W'(256));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, 64'h3));
    wait_idle();
    write_warn_threshold(gst_pkg::WARN_W'(255));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, 64'h4));
  endtask

  // Random traffic in phases, one step value per phase, varied sender gaps.
  task automatic test_random_traffic();
    logic [gst_pkg::WARN_W-1:0] steps [6];
    steps = '{gst_pkg::WARN_W'(256), gst_pkg::WARN_W'(5), gst_pkg::WARN_W'(255),
              gst_pkg::WARN_W'(0), gst_pkg::WARN_W'(12), gst_pkg::WARN_W'(2)};
    foreach (steps[p]) begin
      wait_idle();
      write_warn_threshold(steps[p]);
      gap_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 25 : 8);
      repeat (225) send_request(random_request(1'b0));
    end
  endtask

  // Grow to the last slot (step 1 makes the final grow report level 256),
  // hit the full condition, then recycle a few slots.
  task automatic test_fill_table();
    int idx;
    wait_idle();
    write_warn_threshold(gst_pkg::WARN_W'(1));
    while (!(free_count == 0 && grown_slots == gst_pkg::MAX_SLOTS))
      send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, {$urandom, $urandom} | 64'h1));
    repeat (3) send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, {$urandom, $urandom}));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, '0));
    repeat (3) begin
      idx = $urandom_range(0, gst_pkg::MAX_SLOTS - 1);
      send_request(make_req(gst_pkg::REQ_FREE, 1, idx, slot_gen[idx], '0));
    end
    repeat (4)
      send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, {$urandom, $urandom} | 64'h1));
  endtask

  // After shutdown only null payload and unset handle outrank the lockout.
  task automatic test_shutdown_lockout();
    send_request(make_req(gst_pkg::REQ_RESOLVE, 1, 7, slot_gen[7], '0));
    send_request(make_req(gst_pkg::REQ_SHUTDOWN, 0, 0, '0, '0));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, 64'h77));
    send_request(make_req(gst_pkg::REQ_ALLOC, 1, 0, '0, '0));
    send_request(make_req(gst_pkg::REQ_FREE, 0, 3, slot_gen[3], '0));
    send_request(make_req(gst_pkg::REQ_FREE, 1, 3, slot_gen[3], '0));
    send_request(make_req(gst_pkg::REQ_RESOLVE, 1, 4, slot_gen[4], '0));
    send_request(make_req(gst_pkg::REQ_RESOLVE, 1, 200, '0, '0));
    send_request(make_req(gst_pkg::REQ_SHUTDOWN, 1, 255, '1, '1));
    repeat (30) send_request(random_request(1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    mismatches  = 0;
    no_idle     = 1'b0;
    gap_pct     = 10;
    foreach (slot_gen[i]) begin
      slot_gen[i]     = '0;
      slot_payload[i] = '0;
      free_slots[i]   = 0;
    end
    free_count   = 0;
    grown_slots  = 0;
    top_multiple = 0;
    locked_out   = 1'b0;
    warn_step    = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    wait_idle();
    write_warn_threshold(gst_pkg::WARN_W'(1));
    test_handle_lifecycle();
    test_warn_rescale();
    test_random_traffic();

    // Tail of the run: no idling on either side.
    wait_idle();
    no_idle = 1'b1;
    test_fill_table();
    test_shutdown_lockout();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog, many times the slowest legal run.
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ generational_slot_table_top.f @@
sv/gst_pkg.sv
sv/gst_front.sv
sv/gst_fifo.sv
sv/gst_div.sv
sv/gst_back.sv
sv/generational_slot_table_top.sv
tb/sv/generational_slot_table_top_test.sv
